FILE: hw/rtl/ttcs_pkg.sv
// Shared types and command codes for the terminal cursor store.
package ttcs_pkg;

  typedef enum logic [4:0] {
    M_PUTC = 5'd0, M_RAW = 5'd1, M_SETC = 5'd2, M_PUTXY = 5'd3, M_GOTO = 5'd4,
    M_SETX = 5'd5, M_MOVEX = 5'd6, M_MOVEY = 5'd7, M_SOL = 5'd8, M_CFWD = 5'd9,
    M_LFWD = 5'd10, M_LF = 5'd11, M_CBACK = 5'd12, M_LBACK = 5'd13,
    M_SCRUP = 5'd14, M_SCRDN = 5'd15, M_CLS = 5'd16, M_CLL = 5'd17,
    M_CLEOL = 5'd18, M_ERS = 5'd19, M_ERL = 5'd20, M_MARG = 5'd21,
    M_RMARG = 5'd22, M_REV = 5'd23, M_SHOW = 5'd24, M_HIDE = 5'd25,
    M_INV = 5'd26, M_READ = 5'd27, M_NOP28 = 5'd28, M_NOP29 = 5'd29,
    M_NOP30 = 5'd30, M_NOP31 = 5'd31
  } mode_t;

  localparam logic [1:0] EK_TO_END = 2'd0;
  localparam logic [1:0] EK_TO_CUR = 2'd1;
  localparam logic [1:0] EK_ALL    = 2'd2;
  localparam logic [1:0] EK_NONE   = 2'd3;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] BIT7      = 8'h80;

  typedef struct packed {
    logic [4:0]        mode;
    logic signed [7:0] pos_x;
    logic signed [7:0] pos_y;
    logic signed [7:0] step;
    logic [7:0]        char_code;
    logic [1:0]        erase_kind;
    logic signed [7:0] top_row;
    logic signed [7:0] bottom_row;
    logic [7:0]        range_len;
    logic              reverse_on;
  } in_word_t;

  typedef struct packed {
    logic [7:0] read_char;
    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic       cursor_visible;
    logic [4:0] top_margin;
    logic [4:0] bottom_margin;
  } out_word_t;

  // memory operation kinds
  typedef enum logic [2:0] {
    OP_NONE = 3'd0, OP_WRITE = 3'd1, OP_FILL = 3'd2, OP_COPY = 3'd3,
    OP_INV = 3'd4, OP_READ = 3'd5
  } mop_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic again;
    logic wr_en;
    logic step;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    mop_t op;
    logic last;
    logic again;
  } sts_t;

endpackage

FILE: hw/rtl/ttcs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module ttcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1920
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

FILE: hw/rtl/ttcs_ctrl.sv
// Sequencer: clearing pass after reset, then decode, read, write, sweep and result phases of each command.
module ttcs_ctrl import ttcs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic out_stall,
  output logic out_valid,
  input  sts_t sts,
  output cmd_t cmd
);
  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_DEC  = 6'b000100,
    S_RD   = 6'b001000,
    S_WR   = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall  = !(state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      S_CLR: begin
        cmd.wr_en = 1'b1;
        cmd.step  = 1'b1;
        if (sts.last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        case (sts.op)
          OP_NONE:  state_nxt = S_OUT;
          OP_WRITE, OP_FILL: state_nxt = S_WR;
          default: state_nxt = S_RD;
        endcase
        if (sts.op == OP_NONE) cmd.finish = 1'b1;
      end
      S_RD: begin
        state_nxt = S_WR;
        if (sts.op == OP_READ) begin
          cmd.finish = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_WR: begin
        cmd.wr_en = 1'b1;
        cmd.step = 1'b1;
        if (sts.last) begin
          // scroll done ahead of a character: decode the held word again
          if (sts.again) begin
            cmd.load  = 1'b1;
            cmd.again = 1'b1;
            state_nxt = S_DEC;
          end else begin
            cmd.finish = 1'b1;
            state_nxt = S_OUT;
          end
        end else if (sts.op != OP_FILL) begin
          state_nxt = S_RD;
        end
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLR;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load && !cmd.again) |-> state_r == S_IDLE)
    else $error("load outside idle");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> !cmd.wr_en)
    else $error("write while presenting result");
endmodule

FILE: hw/rtl/ttcs_dp.sv
// Datapath: cursor, margins, command decode, address sweep and cell store.
module ttcs_dp import ttcs_pkg::*; #(
  parameter int COLS = 80,
  parameter int ROWS = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_data,
  input  cmd_t      cmd,
  output sts_t      sts,
  output out_word_t out_data
);
  localparam int N  = COLS * ROWS;
  localparam int AW = $clog2(N);
  localparam int CW = 7;
  localparam int RW = 5;
  localparam int SW = 16;

  typedef logic signed [SW-1:0] sv_t;

  localparam sv_t SCOLS = sv_t'(COLS);
  localparam sv_t SROWS = sv_t'(ROWS);
  localparam sv_t SN    = sv_t'(N);

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [RW-1:0] top_r, top_nxt;
  logic [RW-1:0] bot_r, bot_nxt;
  logic          rev_r, rev_nxt;
  logic          shown_r, shown_nxt;
  mop_t          op_r, op_nxt;
  logic [AW-1:0] a_r, a_nxt, e_r, e_nxt;
  logic          dn_r, dn_nxt;
  logic [AW:0]   src_r, src_nxt;
  logic [7:0]    wd_r, wd_nxt;
  logic [7:0]    rd_q_r;
  logic          rdhit_r, rdhit_nxt;
  logic          rdon_r, rdon_nxt;
  logic          again_r, again_nxt;
  in_word_t      in_r;
  in_word_t      iw;
  logic [7:0]    mem_q;
  logic [AW-1:0] wa;
  logic [7:0]    wdat;
  logic [AW-1:0] ra;

  sv_t px, py, st, cc, cr, tp, bt;

  // held word when a character is decoded again after its scroll
  assign iw = cmd.again ? in_r : in_data;

  always_comb begin
    sv_t t, b, here, first, last, lc, v;
    logic [7:0] fillv;
    mop_t op;
    logic dn;
    logic ag;
    sv_t sa, se, ssrc;
    logic [7:0] wd;

    px = sv_t'(iw.pos_x);
    py = sv_t'(iw.pos_y);
    st = sv_t'(iw.step);
    cc = sv_t'({1'b0, col_r});
    cr = sv_t'({1'b0, row_r});
    tp = sv_t'({1'b0, top_r});
    bt = sv_t'({1'b0, bot_r});
    fillv = rev_r ? BIT7 : 8'h00;
    col_nxt = col_r; row_nxt = row_r; top_nxt = top_r; bot_nxt = bot_r;
    rev_nxt = rev_r; shown_nxt = shown_r;
    op = OP_NONE; dn = 1'b0; ag = 1'b0; sa = '0; se = '0; ssrc = '0; wd = fillv;
    rdhit_nxt = 1'b0; rdon_nxt = 1'b0;
    t = '0; b = '0; here = cr * SCOLS; first = '0; last = '0; v = '0;
    lc = (cc < SCOLS) ? cc : SCOLS - 1;

    case (mode_t'(iw.mode))
      M_PUTC, M_RAW: begin
        v = cr; lc = cc;
        if (cc >= SCOLS) begin
          lc = '0;
          // pending wrap at the bottom: scroll first, then decode again
          if (cr + 1 > bt) begin
            op = OP_COPY; v = bt; ag = 1'b1;
          end else v = cr + 1;
        end
        if (!ag) begin
          if (iw.mode == M_PUTC && iw.char_code == CH_CR) begin
            lc = '0;
          end else if (iw.mode == M_PUTC && iw.char_code == CH_LF) begin
            lc = '0;
            if (v + 1 > bt) begin
              op = OP_COPY; v = bt;
            end else v = v + 1;
          end else begin
            op = OP_WRITE;
            sa = v * SCOLS + lc;
            se = sa;
            wd = iw.char_code ^ fillv;
            lc = lc + 1;
          end
        end
        col_nxt = lc[CW-1:0];
        row_nxt = v[RW-1:0];
        if (op == OP_COPY) begin
          sa = tp * SCOLS; se = bt * SCOLS + SCOLS - 1; ssrc = sa + SCOLS;
        end
      end
      M_SETC: begin
        if (cc < SCOLS) begin
          op = OP_WRITE; sa = here + cc; se = sa; wd = iw.char_code ^ fillv;
        end
      end
      M_PUTXY: begin
        if (px >= 0 && px < SCOLS && py >= 0 && py < SROWS) begin
          op = OP_WRITE; sa = py * SCOLS + px; se = sa;
          wd = iw.char_code ^ fillv;
        end
      end
      M_GOTO: begin
        v = px < 0 ? sv_t'(0) : (px > SCOLS - 1 ? SCOLS - 1 : px);
        col_nxt = v[CW-1:0];
        v = py < 0 ? sv_t'(0) : (py > SROWS - 1 ? SROWS - 1 : py);
        row_nxt = v[RW-1:0];
      end
      M_SETX: begin
        v = px < 0 ? sv_t'(0) : (px > SCOLS - 1 ? SCOLS - 1 : px);
        col_nxt = v[CW-1:0];
      end
      M_MOVEX: begin
        v = cc + st;
        v = v < 0 ? sv_t'(0) : (v > SCOLS - 1 ? SCOLS - 1 : v);
        col_nxt = v[CW-1:0];
      end
      M_MOVEY: begin
        v = cr + st;
        v = v < tp ? tp : (v > bt ? bt : v);
        row_nxt = v[RW-1:0];
      end
      M_SOL: col_nxt = '0;
      M_CFWD, M_LFWD, M_LF: begin
        v = cc + 1;
        if (iw.mode == M_LFWD) v = SCOLS + 1;
        if (iw.mode == M_LF) v = cc;
        if (v > SCOLS || iw.mode == M_LF) begin
          if (iw.mode != M_LF) v = '0;
          if (cr + 1 > bt) begin
            op = OP_COPY; sa = tp * SCOLS; se = bt * SCOLS + SCOLS - 1;
            ssrc = sa + SCOLS; row_nxt = bot_r;
          end else row_nxt = row_r + 1'b1;
        end
        col_nxt = v[CW-1:0];
      end
      M_CBACK, M_LBACK: begin
        v = cc - 1;
        if (iw.mode == M_LBACK || v < 0) begin
          v = SCOLS - 1;
          if (cr - 1 < 0) begin
            v = '0; row_nxt = top_r;
          end else row_nxt = row_r - 1'b1;
        end
        col_nxt = v[CW-1:0];
      end
      M_SCRUP: begin
        op = OP_COPY; sa = tp * SCOLS; se = bt * SCOLS + SCOLS - 1;
        ssrc = sa + SCOLS;
      end
      M_SCRDN: begin
        op = OP_COPY; dn = 1'b1; sa = bt * SCOLS + SCOLS - 1; se = tp * SCOLS;
        ssrc = sa - SCOLS;
      end
      M_CLS: begin
        top_nxt = '0; bot_nxt = RW'(ROWS - 1); col_nxt = '0; row_nxt = '0;
        op = OP_FILL; sa = '0; se = SN - 1;
      end
      M_CLL: begin
        op = OP_FILL; sa = here; se = here + SCOLS - 1; col_nxt = '0;
      end
      M_CLEOL, M_ERL: begin
        first = here; last = here + SCOLS - 1;
        if (iw.mode == M_CLEOL || iw.erase_kind == EK_TO_END)
          first = here + cc;
        else if (iw.erase_kind == EK_TO_CUR) last = here + lc;
        if ((iw.mode == M_CLEOL || iw.erase_kind != EK_NONE) && first <= last) begin
          op = OP_FILL; sa = first; se = last;
        end
      end
      M_ERS: begin
        first = '0; last = SN - 1;
        if (iw.erase_kind == EK_TO_END) first = here + cc;
        else if (iw.erase_kind == EK_TO_CUR) last = here + lc;
        if (iw.erase_kind != EK_NONE && first <= last) begin
          op = OP_FILL; sa = first; se = last;
        end
      end
      M_MARG, M_RMARG: begin
        t = (iw.mode == M_MARG) ? sv_t'(iw.top_row) : sv_t'(0);
        b = (iw.mode == M_MARG) ? sv_t'(iw.bottom_row) : SROWS - 1;
        if (t < 0) t = '0;
        if (b >= SROWS) b = SROWS - 1;
        if (t >= b) begin t = '0; b = SROWS - 1; end
        top_nxt = t[RW-1:0]; bot_nxt = b[RW-1:0];
        col_nxt = '0; row_nxt = t[RW-1:0];
      end
      M_REV: rev_nxt = iw.reverse_on;
      M_SHOW: shown_nxt = 1'b1;
      M_HIDE: shown_nxt = 1'b0;
      M_INV: begin
        if (px >= 0 && px < SCOLS && py >= 0 && py < SROWS && iw.range_len != 0) begin
          op = OP_INV; sa = py * SCOLS + px;
          se = sa + sv_t'({8'd0, iw.range_len}) - 1;
          if (se > SN - 1) se = SN - 1;
          ssrc = sa;
        end
      end
      M_READ: begin
        if (px >= 0 && px < SCOLS && py >= 0 && py < SROWS) begin
          op = OP_READ; sa = py * SCOLS + px; ssrc = sa; rdon_nxt = 1'b1;
          rdhit_nxt = shown_r && cc < SCOLS && px == cc && py == cr;
        end
      end
      default: ;
    endcase
    // scroll of a single-row region (top == bottom) just fills that row
    if (op == OP_COPY && !dn && tp == bt) op = OP_FILL;
    if (op == OP_COPY && dn && tp == bt) begin op = OP_FILL; dn = 1'b0;
      sa = tp * SCOLS; se = sa + SCOLS - 1; end
    op_nxt = op; dn_nxt = dn; again_nxt = ag;
    a_nxt = sa[AW-1:0]; e_nxt = se[AW-1:0]; src_nxt = ssrc[AW:0]; wd_nxt = wd;
  end

  // address sweep; copy rows within range, fill at far end
  logic in_copy_range;
  assign in_copy_range = dn_r ? (src_r[AW] == 1'b0 && src_r[AW-1:0] >= e_r)
                              : (src_r <= {1'b0, e_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0; row_r <= '0; top_r <= '0; bot_r <= RW'(ROWS - 1);
      rev_r <= 1'b0; shown_r <= 1'b0; op_r <= OP_FILL; dn_r <= 1'b0;
      a_r <= '0; e_r <= AW'(N - 1); wd_r <= '0; rdon_r <= 1'b0; rdhit_r <= 1'b0;
      src_r <= '0; again_r <= 1'b0; in_r <= '0;
    end else begin
      if (cmd.load) begin
        col_r <= col_nxt; row_r <= row_nxt; top_r <= top_nxt; bot_r <= bot_nxt;
        rev_r <= rev_nxt; shown_r <= shown_nxt; op_r <= op_nxt; dn_r <= dn_nxt;
        a_r <= a_nxt; e_r <= e_nxt; src_r <= src_nxt; wd_r <= wd_nxt;
        rdon_r <= rdon_nxt; rdhit_r <= rdhit_nxt; again_r <= again_nxt;
        in_r <= iw;
      end else if (cmd.step) begin
        if (dn_r) begin
          a_r <= a_r - 1'b1; src_r <= src_r - 1'b1;
        end else begin
          a_r <= a_r + 1'b1; src_r <= src_r + 1'b1;
        end
      end
      if (cmd.finish && op_r != OP_READ) rdon_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) rd_q_r <= mem_q;
  end

  assign ra   = src_r[AW-1:0];
  assign wa   = a_r;
  assign wdat = (op_r == OP_INV) ? (mem_q ^ BIT7) :
                (op_r == OP_COPY && in_copy_range) ? mem_q :
                (op_r == OP_COPY) ? (rev_r ? BIT7 : 8'h00) : wd_r;

  ttcs_ram #(.WIDTH(8), .DEPTH(N)) u_ram (
    .clk(clk), .wr_en(cmd.wr_en), .wr_addr(wa), .wr_data(wdat),
    .rd_addr(ra), .rd_data(mem_q)
  );

  assign sts.op    = op_r;
  assign sts.last  = (a_r == e_r);
  assign sts.again = again_r;

  assign out_data.read_char      = rdon_r ? (rd_q_r ^ (rdhit_r ? BIT7 : 8'h00)) : 8'h00;
  assign out_data.cursor_col     = col_r;
  assign out_data.cursor_row     = row_r;
  assign out_data.cursor_visible = shown_r;
  assign out_data.top_margin     = top_r;
  assign out_data.bottom_margin  = bot_r;
endmodule

FILE: hw/rtl/text_terminal_cursor_store_top.sv
// A cursor-only command goes from decode straight to the result; a single-cell read or
// write passes through the read or write state first. Sweeps (scroll, erase, invert):
// copy/invert alternate read and write states for each cell and fills write each cell
// with no read, due to the single write port and registered read; a character on a pending
// wrap at the bottom margin scrolls first. One command at a time; result waits until taken.
// Reset: synchronous; a clearing pass over all COLS*ROWS cells runs before the first command.
module text_terminal_cursor_store_top import ttcs_pkg::*; #(
  parameter int COLS = 80,
  parameter int ROWS = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);
  cmd_t cmd;
  sts_t sts;

  ttcs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_stall(out_stall), .out_valid(out_valid), .sts(sts), .cmd(cmd)
  );

  ttcs_dp #(.COLS(COLS), .ROWS(ROWS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cmd(cmd), .sts(sts),
    .out_data(out_data)
  );
endmodule

FILE: sim/text_terminal_cursor_store_top_tb.sv
// Testbench for the terminal cursor store: self-checking predictor, random stimulus and stalls.
module text_terminal_cursor_store_top_tb;
  import ttcs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS = 80;
  localparam int ROWS = 24;
  localparam int CELLS = COLS * ROWS;
  localparam int IDLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;

  text_terminal_cursor_store_top #(.COLS(COLS), .ROWS(ROWS)) dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow terminal state
  logic [7:0] cells [CELLS];
  int cur_col, cur_row, mtop, mbot;
  bit rev_fill, shown;
  out_word_t pending_results[$];
  int fail_count = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  int hold_len = 0;

  function automatic int clamp(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [7:0] fill_byte();
    return rev_fill ? BIT7 : 8'h00;
  endfunction

  function automatic void fill_range(int first, int last);
    if (first < 0) first = 0;
    if (last > CELLS - 1) last = CELLS - 1;
    for (int i = first; i <= last; i++) cells[i] = fill_byte();
  endfunction

  function automatic void region_up();
    for (int r = mtop; r < mbot; r++)
      for (int c = 0; c < COLS; c++) cells[r*COLS+c] = cells[(r+1)*COLS+c];
    fill_range(mbot*COLS, mbot*COLS + COLS - 1);
  endfunction

  function automatic void region_down();
    for (int r = mbot; r > mtop; r--)
      for (int c = 0; c < COLS; c++) cells[r*COLS+c] = cells[(r-1)*COLS+c];
    fill_range(mtop*COLS, mtop*COLS + COLS - 1);
  endfunction

  function automatic void feed_line();
    cur_row++;
    if (cur_row > mbot) begin
      cur_row = mbot;
      region_up();
    end
  endfunction

  function automatic void new_line();
    cur_col = 0;
    feed_line();
  endfunction

  function automatic void advance_col();
    cur_col++;
    if (cur_col > COLS) new_line();
  endfunction

  function automatic void back_line();
    cur_col = COLS - 1;
    cur_row--;
    if (cur_row < 0) begin
      cur_col = 0;
      cur_row = mtop;
    end
  endfunction

  function automatic void print_char(logic [7:0] ch, bit interp);
    if (cur_col >= COLS) new_line();
    if (interp && ch == CH_CR) cur_col = 0;
    else if (interp && ch == CH_LF) new_line();
    else begin
      cells[cur_row*COLS+cur_col] = ch ^ fill_byte();
      advance_col();
    end
  endfunction

  function automatic void apply_margins(int t, int b);
    if (t < 0) t = 0;
    if (b >= ROWS) b = ROWS - 1;
    if (t >= b) begin
      t = 0;
      b = ROWS - 1;
    end
    mtop = t;
    mbot = b;
    cur_col = 0;
    cur_row = mtop;
  endfunction

  function automatic int last_incl();
    return cur_col < COLS ? cur_col : COLS - 1;
  endfunction

  function automatic void erase_line_kind(logic [1:0] k);
    int row;
    row = cur_row * COLS;
    if (k == EK_TO_END) fill_range(row + cur_col, row + COLS - 1);
    else if (k == EK_TO_CUR) fill_range(row, row + last_incl());
    else if (k == EK_ALL) fill_range(row, row + COLS - 1);
  endfunction

  function automatic void terminal_reset();
    for (int i = 0; i < CELLS; i++) cells[i] = 8'h00;
    cur_col = 0;
    cur_row = 0;
    mtop = 0;
    mbot = ROWS - 1;
    rev_fill = 1'b0;
    shown = 1'b0;
  endfunction

  function automatic out_word_t run_command(in_word_t w);
    out_word_t r;
    int px, py, st, start;
    bit on_screen;
    logic [7:0] rd;
    px = w.pos_x;
    py = w.pos_y;
    st = w.step;
    rd = 8'h00;
    on_screen = px >= 0 && px < COLS && py >= 0 && py < ROWS;
    case (mode_t'(w.mode))
      M_PUTC: print_char(w.char_code, 1'b1);
      M_RAW: print_char(w.char_code, 1'b0);
      M_SETC: if (cur_col < COLS) cells[cur_row*COLS+cur_col] = w.char_code ^ fill_byte();
      M_PUTXY: if (on_screen) cells[py*COLS+px] = w.char_code ^ fill_byte();
      M_GOTO: begin
        cur_col = clamp(px, 0, COLS - 1);
        cur_row = clamp(py, 0, ROWS - 1);
      end
      M_SETX: cur_col = clamp(px, 0, COLS - 1);
      M_MOVEX: cur_col = clamp(cur_col + st, 0, COLS - 1);
      M_MOVEY: cur_row = clamp(cur_row + st, mtop, mbot);
      M_SOL: cur_col = 0;
      M_CFWD: advance_col();
      M_LFWD: new_line();
      M_LF: feed_line();
      M_CBACK: begin
        cur_col--;
        if (cur_col < 0) back_line();
      end
      M_LBACK: back_line();
      M_SCRUP: region_up();
      M_SCRDN: region_down();
      M_CLS: begin
        apply_margins(0, ROWS - 1);
        fill_range(0, CELLS - 1);
        cur_col = 0;
        cur_row = 0;
      end
      M_CLL: begin
        erase_line_kind(EK_ALL);
        cur_col = 0;
      end
      M_CLEOL: erase_line_kind(EK_TO_END);
      M_ERS: begin
        if (w.erase_kind == EK_TO_END) fill_range(cur_row*COLS + cur_col, CELLS - 1);
        else if (w.erase_kind == EK_TO_CUR) fill_range(0, cur_row*COLS + last_incl());
        else if (w.erase_kind == EK_ALL) fill_range(0, CELLS - 1);
      end
      M_ERL: erase_line_kind(w.erase_kind);
      M_MARG: apply_margins(int'(w.top_row), int'(w.bottom_row));
      M_RMARG: apply_margins(0, ROWS - 1);
      M_REV: rev_fill = w.reverse_on;
      M_SHOW: shown = 1'b1;
      M_HIDE: shown = 1'b0;
      M_INV: if (on_screen) begin
        start = py * COLS + px;
        for (int i = 0; i < w.range_len && start + i < CELLS; i++)
          cells[start+i] ^= BIT7;
      end
      M_READ: if (on_screen) begin
        rd = cells[py*COLS+px];
        if (shown && cur_col < COLS && px == cur_col && py == cur_row) rd ^= BIT7;
      end
      default: ;
    endcase
    r.read_char = rd;
    r.cursor_col = cur_col[6:0];
    r.cursor_row = cur_row[4:0];
    r.cursor_visible = shown;
    r.top_margin = mtop[4:0];
    r.bottom_margin = mbot[4:0];
    return r;
  endfunction

  // sender: bursts with gaps
  int burst_left = 0;

  task automatic send_word(in_word_t w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 2) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(run_command(w));
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
  endtask

  function automatic in_word_t rand_word();
    in_word_t w;
    w = in_word_t'({$urandom, $urandom});
    w.erase_kind = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 1)) begin
      w.pos_x = 8'($urandom_range(0, COLS + 2) - 1);
      w.pos_y = 8'($urandom_range(0, ROWS + 2) - 1);
    end
    if ($urandom_range(0, 1)) begin
      w.top_row = 8'($urandom_range(0, ROWS + 1) - 1);
      w.bottom_row = 8'($urandom_range(0, ROWS + 1) - 1);
    end
    if ($urandom_range(0, 3) == 0) w.step = 8'($urandom_range(0, 6) - 3);
    return w;
  endfunction

  function automatic in_word_t cmd(mode_t m);
    in_word_t w;
    w = rand_word();
    w.mode = m;
    return w;
  endfunction

  task automatic test_directed();
    in_word_t w;
    for (int m = 0; m < 32; m++) send_word(cmd(mode_t'(m)));
    w = cmd(M_GOTO); w.pos_x = 8'sh7f; w.pos_y = -8'sd128; send_word(w);
    w = cmd(M_GOTO); w.pos_x = -8'sd128; w.pos_y = 8'sh7f; send_word(w);
    w = cmd(M_SETX); w.pos_x = 8'(COLS - 1); send_word(w);
    w = cmd(M_RAW); w.char_code = 8'hff; send_word(w);
    w = cmd(M_SETC); send_word(w);
    send_word(cmd(M_SHOW));
    w = cmd(M_READ); w.pos_x = 8'(COLS - 1); w.pos_y = 8'(ROWS - 1); send_word(w);
    w = cmd(M_ERS); w.erase_kind = EK_TO_CUR; send_word(w);
    w = cmd(M_MARG); w.top_row = -8'sd5; w.bottom_row = 8'sd100; send_word(w);
    w = cmd(M_MARG); w.top_row = 8'sd10; w.bottom_row = 8'sd3; send_word(w);
    w = cmd(M_INV); w.pos_x = 8'(COLS - 3); w.pos_y = 8'(ROWS - 1); w.range_len = 8'hff;
    send_word(w);
    w = cmd(M_PUTXY); w.pos_x = 8'(COLS); w.pos_y = 8'sd0; send_word(w);
    w = cmd(M_REV); w.reverse_on = 1'b1; send_word(w);
    send_word(cmd(M_SCRDN));
  endtask

  // random commands weighted toward characters, with controls, margins and reads
  task automatic test_random(int count);
    in_word_t w;
    for (int n = 0; n < count; n++) begin
      w = rand_word();
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          w.mode = M_PUTC;
          if ($urandom_range(0, 7) == 0) w.char_code = $urandom_range(0, 1) ? CH_CR : CH_LF;
        end
        3: w.mode = M_READ;
        4: w.mode = $urandom_range(0, 1) ? M_RAW : M_LF;
        5: w.mode = $urandom_range(0, 1) ? M_MARG : M_MOVEY;
        default: w.mode = 5'($urandom_range(0, 31));
      endcase
      if (w.mode == M_CLS && $urandom_range(0, 3) != 0) w.mode = M_READ;
      send_word(w);
    end
  endtask

  task automatic test_backpressure();
    hold_len = 300;
    hold_off = 1'b1;
    test_random(20);
    end_burst();
    wait (!hold_off);
  endtask

  task automatic test_drain();
    end_burst();
    while (pending_results.size() != 0) @(posedge clk);
    test_random(10);
  endtask

  // receiver stall pattern
  int stall_phase = 0;
  always @(posedge clk) begin
    if (hold_off) begin
      out_stall <= 1'b1;
      hold_len--;
      if (hold_len <= 0) hold_off <= 1'b0;
    end else begin
      stall_phase++;
      if ((stall_phase / 200) % 2 == 0) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 2) == 0);
    end
  end

  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result %p", out_data);
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        if (out_data.read_char !== e.read_char) begin
          $error("read_char exp %0h got %0h", e.read_char, out_data.read_char); fail_count++;
        end
        if (out_data.cursor_col !== e.cursor_col) begin
          $error("cursor_col exp %0d got %0d", e.cursor_col, out_data.cursor_col); fail_count++;
        end
        if (out_data.cursor_row !== e.cursor_row) begin
          $error("cursor_row exp %0d got %0d", e.cursor_row, out_data.cursor_row); fail_count++;
        end
        if (out_data.cursor_visible !== e.cursor_visible) begin
          $error("cursor_visible exp %0d got %0d", e.cursor_visible, out_data.cursor_visible);
          fail_count++;
        end
        if (out_data.top_margin !== e.top_margin) begin
          $error("top_margin exp %0d got %0d", e.top_margin, out_data.top_margin); fail_count++;
        end
        if (out_data.bottom_margin !== e.bottom_margin) begin
          $error("bottom_margin exp %0d got %0d", e.bottom_margin, out_data.bottom_margin);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("text_terminal_cursor_store_top_tb failed");
      $finish;
    end
  end

  initial begin
    terminal_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_drain();
    test_random(1250);
    end_burst();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("text_terminal_cursor_store_top_tb passed");
    else $display("text_terminal_cursor_store_top_tb failed");
    $finish;
  end
endmodule

FILE: filelist.f
hw/rtl/ttcs_pkg.sv
hw/rtl/ttcs_ram.sv
hw/rtl/ttcs_ctrl.sv
hw/rtl/ttcs_dp.sv
hw/rtl/text_terminal_cursor_store_top.sv
sim/text_terminal_cursor_store_top_tb.sv
